### rtl/hcbp_pkg.sv
// hcbp_pkg: shared constants, types and helpers of the huffman code bit packer
// used by huffman_code_bit_packer_top and hcbp_checker; no dependencies
package hcbp_pkg;

  localparam int MAX_CODE_LEN    = 32;
  localparam int SYMBOLS_DEFAULT = 256;
  localparam int BYTE_BITS       = 8;
  localparam int CODE_W          = 32;
  localparam int LEN_W           = 6;
  localparam int SYM_W           = 8;
  localparam int OFS_W           = 3;
  localparam int VBITS_W         = 4;
  localparam int LEN_CAP         = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  // accumulator byte plus the longest code shifted by the largest fill
  localparam int WORD_W          = CODE_W + BYTE_BITS;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 16;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  // table entry: code already reversed and right-aligned for lsb-first packing
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] rev;
  } tbl_entry_t;

  function automatic logic [CODE_W-1:0] bit_reverse(input logic [CODE_W-1:0] v);
    logic [CODE_W-1:0] r;
    for (int i = 0; i < CODE_W; i++) begin
      r[i] = v[CODE_W-1-i];
    end
    return r;
  endfunction

endpackage

### rtl/huffman_code_bit_packer_top.sv
// huffman_code_bit_packer_top: code table in a synchronous ram, lsb-first bit packer
// depends on hcbp_pkg; hcbp_checker is bound to it from its own file
// latency: an encode transaction registers its table read and item flags, then the pack
//   stage loads the output register, which offers the first result byte
// throughput: one item per cycle while each item yields at most one byte and the
//   receiver accepts; an item holds the output register until its last result byte
//   is taken (up to five, a 32-bit code plus offset fills four bytes)
// reset: control state, accumulator and stream flag are cleared; the code table is
//   not cleared and holds nothing meaningful until loaded
module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOLS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [OFS_W-1:0]      cfg_wdata,   // start_bit_offset
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,     // symbol[7:0], code_bits[39:8], code_len[45:40]
  input  logic                  s_tuser,     // func
  input  logic                  s_tlast,     // last_symbol
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,     // out_byte[7:0], valid_bits[11:8]
  output logic                  m_tlast      // last_byte
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [OFS_W-1:0] start_bit_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_bit_offset <= '0;
    end else if (cfg_we) begin
      start_bit_offset <= cfg_wdata;
    end
  end

  // input fields
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic              in_hit;
  logic              in_acc;
  logic [LEN_W-1:0]  len_sat;
  tbl_entry_t        wr_entry;

  assign in_symbol = s_tdata[SYM_W-1:0];
  assign in_code   = s_tdata[SYM_W+CODE_W-1:SYM_W];
  assign in_len    = s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
  assign in_hit    = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign in_acc    = s_tvalid && s_tready;
  assign len_sat   = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;

  always_comb begin
    wr_entry.len = len_sat;
    wr_entry.rev = bit_reverse(in_code) >> (LEN_W'(CODE_W) - len_sat);
  end

  // code table, read at acceptance of an encode, written at acceptance of an in-range load
  tbl_entry_t table_mem [SYMBOL_COUNT];
  tbl_entry_t rd_entry;

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == FUNC_LOAD && in_hit) begin
      table_mem[in_symbol[IDX_W-1:0]] <= wr_entry;
    end
    if (in_acc && s_tuser == FUNC_ENCODE) begin
      rd_entry <= table_mem[in_symbol[IDX_W-1:0]];
    end
  end

  // pack stage
  logic b_valid;
  logic b_hit;
  logic b_last;
  logic b_adv;
  logic buf_free;

  logic             stream_open;
  logic [7:0]       acc;
  logic [OFS_W-1:0] fill;

  logic [OFS_W-1:0]  fill_eff;
  logic [7:0]        acc_eff;
  logic [CODE_W-1:0] rev_eff;
  logic [LEN_W-1:0]  len_eff;
  logic [WORD_W-1:0] word;
  logic [LEN_W-1:0]  total;
  logic [2:0]        nb;
  logic [OFS_W-1:0]  rem;
  logic [2:0]        n_res;
  logic [7:0]        acc_next;

  assign s_tready = !b_valid || buf_free;
  assign b_adv    = b_valid && buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_tready) begin
      b_valid <= in_acc && s_tuser == FUNC_ENCODE;
    end
    if (in_acc) begin
      b_hit  <= in_hit;
      b_last <= s_tlast;
    end
  end

  always_comb begin
    fill_eff = stream_open ? fill : start_bit_offset;
    acc_eff  = stream_open ? acc : 8'd0;
    rev_eff  = b_hit ? rd_entry.rev : '0;
    len_eff  = b_hit ? rd_entry.len : '0;
    word     = {{CODE_W{1'b0}}, acc_eff} | ({8'd0, rev_eff} << fill_eff);
    total    = LEN_W'(fill_eff) + len_eff;
    nb       = total[5:3];
    rem      = total[2:0];
    acc_next = 8'(word >> {nb, 3'b000});
    if (b_last && (rem != '0 || nb == 3'd0)) begin
      n_res = nb + 3'd1;
    end else if (b_last) begin
      n_res = nb;
    end else begin
      n_res = nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_open <= 1'b0;
      acc         <= '0;
      fill        <= '0;
    end else if (b_adv) begin
      if (b_last) begin
        stream_open <= 1'b0;
        acc         <= '0;
        fill        <= '0;
      end else begin
        stream_open <= 1'b1;
        acc         <= acc_next;
        fill        <= rem;
      end
    end
  end

  // output register: bytes of one item, drained one per transaction
  logic [WORD_W-1:0]  obuf;
  logic [2:0]         ocnt;
  logic [2:0]         ofull;
  logic [OFS_W-1:0]   orem;
  logic               ofinal;
  logic               out_acc;
  logic [VBITS_W-1:0] out_vbits;

  assign m_tvalid  = (ocnt != 3'd0);
  assign out_acc   = m_tvalid && m_tready;
  assign buf_free  = (ocnt == 3'd0) || (ocnt == 3'd1 && m_tready);
  assign out_vbits = (ofull != 3'd0) ? VBITS_W'(BYTE_BITS) : VBITS_W'(orem);
  assign m_tdata   = {{(OUT_DATA_W-8-VBITS_W){1'b0}}, out_vbits, obuf[7:0]};
  assign m_tlast   = ofinal && (ocnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (b_adv) begin
      ocnt <= n_res;
    end else if (out_acc) begin
      ocnt <= ocnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      obuf   <= word;
      ofull  <= nb;
      orem   <= rem;
      ofinal <= b_last;
    end else if (out_acc) begin
      obuf <= obuf >> BYTE_BITS;
      if (ofull != 3'd0) begin
        ofull <= ofull - 3'd1;
      end
    end
  end

endmodule

### rtl/hcbp_checker.sv
// hcbp_checker: port-level assertions on the result stream of the bit packer
// depends on hcbp_pkg; bound to huffman_code_bit_packer_top below
module hcbp_checker
  import hcbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // only the final byte of a stream may be partial
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[11:8] == 4'd8)
    else $error("partial byte before end of stream");

  // bits above the valid count are zero
  a_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] >> m_tdata[11:8]) == 8'd0 && m_tdata[11:8] <= 4'd8)
    else $error("stray bits above valid count");

  // nothing is offered straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (.*);

### tb/huffman_code_bit_packer_top_tb.sv
// huffman_code_bit_packer_top_tb: self-checking bench for the lsb-first huffman bit packer
// queued load/encode transactions are scored against an in-bench packer and code table
// depends on hcbp_pkg and huffman_code_bit_packer_top only
module huffman_code_bit_packer_top_tb;
  import hcbp_pkg::*;

  typedef struct {
    logic              func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } hc_item_t;

  typedef struct {
    logic [7:0]         out_byte;
    logic [VBITS_W-1:0] vbits;
    logic               last;
  } packed_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [OFS_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // symbol[7:0], code_bits[39:8], code_len[45:40]
  logic                  s_tuser = 1'b0; // func
  logic                  s_tlast = 1'b0; // last_symbol
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // out_byte[7:0], valid_bits[11:8]
  logic                  m_tlast;        // last_byte

  huffman_code_bit_packer_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hc_item_t     item_q[$];
  packed_byte_t byte_q[$];
  int           fail_cnt = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  logic         hold_go = 1'b0;
  logic         rx_hold = 1'b0;

  // packer state as the block should hold it
  logic [CODE_W-1:0] tbl_code [SYMBOLS_DEFAULT];
  int                tbl_len  [SYMBOLS_DEFAULT];
  logic [7:0]        pk_acc = '0;
  int                pk_fill = 0;
  logic              pk_open = 1'b0;
  logic [OFS_W-1:0]  pk_ofs = '0;

  // stimulus-side view of which table entries hold a code
  logic              in_table [SYMBOLS_DEFAULT];
  logic [SYM_W-1:0]  known_syms[$];

  task automatic pack_item(input hc_item_t it);
    int           clen;
    int           n_out;
    packed_byte_t r;
    n_out = 0;
    if (it.func == FUNC_LOAD) begin
      clen = int'(it.len);
      tbl_code[it.symbol] = it.code;
      tbl_len[it.symbol]  = (clen > LEN_CAP) ? LEN_CAP : clen;
      return;
    end
    if (!pk_open) begin
      pk_acc  = '0;
      pk_fill = int'(pk_ofs);
      pk_open = 1'b1;
    end
    clen = tbl_len[it.symbol];
    // codeword goes out from its top position down
    for (int k = 0; k < clen; k++) begin
      pk_acc[pk_fill] = tbl_code[it.symbol][clen-1-k];
      pk_fill++;
      if (pk_fill == BYTE_BITS) begin
        r.out_byte = pk_acc;
        r.vbits    = VBITS_W'(BYTE_BITS);
        r.last     = 1'b0;
        byte_q.push_back(r);
        n_out++;
        pk_acc  = '0;
        pk_fill = 0;
      end
    end
    if (it.last) begin
      if (pk_fill > 0) begin
        r.out_byte = pk_acc;
        r.vbits    = VBITS_W'(pk_fill);
        r.last     = 1'b1;
        byte_q.push_back(r);
      end else if (n_out > 0) begin
        byte_q[byte_q.size()-1].last = 1'b1;
      end else begin
        r.out_byte = '0;
        r.vbits    = '0;
        r.last     = 1'b1;
        byte_q.push_back(r);
      end
      pk_acc  = '0;
      pk_fill = 0;
      pk_open = 1'b0;
    end
  endtask

  // driver: holds the offered item until its transaction, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        pack_item(item_q[0]);
        void'(item_q.pop_front());
      end
      if (item_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser  <= item_q[0].func;
        s_tlast  <= item_q[0].last;
        s_tdata  <= {2'b00, item_q[0].len, item_q[0].code, item_q[0].symbol};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  packed_byte_t mon_want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (byte_q.size() == 0) begin
        $error("unexpected byte: out_byte %0h valid_bits %0d last_byte %0b",
               m_tdata[7:0], m_tdata[11:8], m_tlast);
        fail_cnt++;
      end else begin
        mon_want = byte_q.pop_front();
        if (m_tdata[7:0] !== mon_want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", mon_want.out_byte, m_tdata[7:0]);
          fail_cnt++;
        end
        if (m_tdata[11:8] !== mon_want.vbits) begin
          $error("valid_bits: expected %0d, got %0d", mon_want.vbits, m_tdata[11:8]);
          fail_cnt++;
        end
        if (m_tlast !== mon_want.last) begin
          $error("last_byte: expected %0b, got %0b", mon_want.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (item_q.size() != 0 || byte_q.size() != 0 || s_tvalid) @(posedge clk);
    // a trailing load can still be in flight with nothing left to score
    repeat (10) @(posedge clk);
  endtask

  task automatic set_offset(input logic [OFS_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pk_ofs = v;
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len, input logic last);
    hc_item_t it;
    it.func   = FUNC_LOAD;
    it.symbol = sym;
    it.code   = code;
    it.len    = len;
    it.last   = last;
    item_q.push_back(it);
    if (!in_table[sym]) begin
      in_table[sym] = 1'b1;
      known_syms.push_back(sym);
    end
  endtask

  task automatic encode_sym(input logic [SYM_W-1:0] sym, input logic last);
    hc_item_t it;
    it.func   = FUNC_ENCODE;
    it.symbol = sym;
    it.code   = $urandom();
    it.len    = LEN_W'($urandom_range(63));
    it.last   = last;
    item_q.push_back(it);
  endtask

  task automatic rand_items(input int n);
    int r;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < n; i++) begin
      if (known_syms.size() == 0 || $urandom_range(99) < 25) begin
        r = $urandom_range(99);
        if (r < 5) len = '0;
        else if (r < 70) len = LEN_W'($urandom_range(10, 1));
        else if (r < 90) len = LEN_W'($urandom_range(32, 11));
        else len = LEN_W'($urandom_range(63, 33));
        load_entry(SYM_W'($urandom_range(255)), $urandom(), len, 1'($urandom_range(1)));
      end else begin
        encode_sym(known_syms[$urandom_range(known_syms.size()-1)], $urandom_range(5) == 0);
      end
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input logic [OFS_W-1:0] ofs,
                           input int n);
    set_offset(ofs);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    rand_items(n);
  endtask

  initial begin
    foreach (in_table[i]) in_table[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_offset(0);
    load_entry(8'h00, 32'h0000_0000, 6'd0,  1'b0);
    load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
    load_entry(8'h5A, 32'h0000_00A5, 6'd8,  1'b0);
    load_entry(8'h01, 32'h0000_0001, 6'd1,  1'b0);
    // over-long lengths clip to the longest code; tlast on a load does nothing
    load_entry(8'h80, 32'hDEAD_BEEF, 6'd63, 1'b1);
    load_entry(8'h7F, 32'h1555_5555, 6'd33, 1'b0);
    encode_sym(8'h00, 1'b1);   // empty stream end
    encode_sym(8'h5A, 1'b1);   // ends exactly on a byte
    encode_sym(8'hFF, 1'b0);
    encode_sym(8'h80, 1'b0);
    encode_sym(8'h7F, 1'b0);
    encode_sym(8'h01, 1'b1);
    encode_sym(8'h01, 1'b0);
    encode_sym(8'h01, 1'b0);
    encode_sym(8'h01, 1'b1);

    set_offset(7);
    encode_sym(8'hFF, 1'b1);   // five bytes from one item
    encode_sym(8'h01, 1'b1);
    encode_sym(8'h00, 1'b1);   // only the offset zeros go out
    encode_sym(8'h5A, 1'b0);
    // new offset must wait for the next stream
    set_offset(3);
    encode_sym(8'h5A, 1'b1);
    encode_sym(8'h01, 1'b1);

    run_phase(0,  0,  0, 40);
    run_phase(58, 0,  7, 40);
    run_phase(0,  58, OFS_W'($urandom_range(7)), 40);
    run_phase(17, 17, 5, 40);

    set_offset(OFS_W'($urandom_range(7)));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_go = 1'b1;
    rand_items(40);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
